>>> rtl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising edge of clk while rstn is high.
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Condition that must never be true while rstn is high.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/pidsmd_pkg.sv
// Shared types and constants for the min-drive PID step core.
// No dependencies.
package pidsmd_pkg;

    localparam int ERROR_WIDTH = 24;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 23;
    localparam int DCFG_W      = 15;
    localparam int DRIVE_W     = 16;

    // accumulator must hold |limit| + |error| without overflow
    localparam int ACC_W  = ((ERROR_WIDTH > LIMIT_W + 1) ? ERROR_WIDTH : LIMIT_W + 1) + 1;
    localparam int DER_W  = ERROR_WIDTH + 1;
    localparam int PP_W   = GAIN_W + 1 + ERROR_WIDTH;
    localparam int PI_W   = GAIN_W + 1 + ACC_W;
    localparam int PD_W   = GAIN_W + 1 + DER_W;
    localparam int SUM_W  = PI_W + 2;
    localparam int SHR_W  = SUM_W - 8;

    localparam int S_TDATA_W  = ((ERROR_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DRIVE_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_INT_LIMIT  = 3'd3,
        REG_ACT_ZONE   = 3'd4,
        REG_SETTLE_THR = 3'd5,
        REG_MAX_DRIVE  = 3'd6,
        REG_MIN_DRIVE  = 3'd7
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]  RST_GAIN_P     = 16'd768;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I     = 16'd49;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D     = 16'd0;
    localparam logic [LIMIT_W-1:0] RST_INT_LIMIT  = 23'd53895;
    localparam logic [LIMIT_W-1:0] RST_ACT_ZONE   = 23'd2560;
    localparam logic [LIMIT_W-1:0] RST_SETTLE_THR = 23'd64;
    localparam logic [DCFG_W-1:0]  RST_MAX_DRIVE  = 15'd25600;
    localparam logic [DCFG_W-1:0]  RST_MIN_DRIVE  = 15'd512;

endpackage

>>> rtl/pid_step_min_drive_core.sv
// Min-drive PID step core: error samples in, drive commands out.
// Depends on pidsmd_pkg and assert_macros.svh.
//
// Usage:
//   Slave stream (s_*): one signed error sample per transaction in
//   s_tdata[ERROR_WIDTH-1:0]. Master stream (m_*): drive command in
//   m_tdata[15:0] (signed), settled flag in m_tuser.
//   APB port: eight registers at byte addresses 0x00..0x1C, write them
//   only while no transaction is in flight.
//   Path: an accepted sample passes the input register, state update,
//   multiply, sum and clamp/output register before it raises m_tvalid.
//   Throughput: one transaction per cycle unless stalled; the integral and
//   previous error update in the single stage that closes the state loop.
//   Each stage holds its own valid bit, so s_tready stays high while any
//   bubble remains in the pipe, even when the receiver stalls; with all
//   five stages full and m_tready low, s_tready drops.
//   Reset (aresetn low, synchronous) empties the pipe, clears integral
//   and previous error and loads the default register values.
module pid_step_min_drive_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // slave stream: [ERROR_WIDTH-1:0] error_in, zero padded to bytes
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pidsmd_pkg::S_TDATA_W-1:0]     s_tdata,
    // master stream: [15:0] drive
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pidsmd_pkg::M_TDATA_W-1:0]     m_tdata,
    // master stream: [0] settled
    output logic                                 m_tuser,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidsmd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pidsmd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pidsmd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                 pready
);
    import pidsmd_pkg::*;

    `include "assert_macros.svh"

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0] int_limit_reg, act_zone_reg, settle_thr_reg;
    logic [DCFG_W-1:0]  max_drive_reg, min_drive_reg;
    logic               cfg_wr;
    cfg_reg_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg     <= RST_GAIN_P;
            gain_i_reg     <= RST_GAIN_I;
            gain_d_reg     <= RST_GAIN_D;
            int_limit_reg  <= RST_INT_LIMIT;
            act_zone_reg   <= RST_ACT_ZONE;
            settle_thr_reg <= RST_SETTLE_THR;
            max_drive_reg  <= RST_MAX_DRIVE;
            min_drive_reg  <= RST_MIN_DRIVE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GAIN_P:     gain_p_reg     <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_reg     <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_reg     <= pwdata[GAIN_W-1:0];
                REG_INT_LIMIT:  int_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_ACT_ZONE:   act_zone_reg   <= pwdata[LIMIT_W-1:0];
                REG_SETTLE_THR: settle_thr_reg <= pwdata[LIMIT_W-1:0];
                REG_MAX_DRIVE:  max_drive_reg  <= pwdata[DCFG_W-1:0];
                REG_MIN_DRIVE:  min_drive_reg  <= pwdata[DCFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GAIN_P:     prdata = CFG_DATA_W'(gain_p_reg);
            REG_GAIN_I:     prdata = CFG_DATA_W'(gain_i_reg);
            REG_GAIN_D:     prdata = CFG_DATA_W'(gain_d_reg);
            REG_INT_LIMIT:  prdata = CFG_DATA_W'(int_limit_reg);
            REG_ACT_ZONE:   prdata = CFG_DATA_W'(act_zone_reg);
            REG_SETTLE_THR: prdata = CFG_DATA_W'(settle_thr_reg);
            REG_MAX_DRIVE:  prdata = CFG_DATA_W'(max_drive_reg);
            REG_MIN_DRIVE:  prdata = CFG_DATA_W'(min_drive_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic adv_state;

    assign rdy4 = !m_valid_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign s_tready = rdy0;
    // a valid sample leaves the input register: state advances
    assign adv_state = v0_reg && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg      <= s_tvalid;
            if (rdy1) v1_reg      <= v0_reg;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) m_valid_reg <= v3_reg;
        end
    end

    // ---------------- stage 0: input register ----------------
    logic signed [ERROR_WIDTH-1:0] err_reg;

    always_ff @(posedge aclk) begin
        if (rdy0) err_reg <= $signed(s_tdata[ERROR_WIDTH-1:0]);
    end

    // ---------------- stage 1: integral and derivative ----------------
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [ERROR_WIDTH-1:0] prev_reg;
    logic signed [ACC_W-1:0]       e_ext, mag, acc_sum, integ_pre;
    logic signed [ACC_W-1:0]       settle_ext, zone_ext, lim_ext;
    logic signed [DER_W-1:0]       deriv_next;
    logic                          settled_next;

    always_comb begin
        e_ext      = ACC_W'(err_reg);
        mag        = (e_ext < 0) ? -e_ext : e_ext;
        settle_ext = $signed(ACC_W'(settle_thr_reg));
        zone_ext   = $signed(ACC_W'(act_zone_reg));
        lim_ext    = $signed(ACC_W'(int_limit_reg));
        settled_next = (mag <= settle_ext);
        acc_sum    = acc_reg + e_ext;
        integ_pre  = (mag < zone_ext) ? acc_sum : '0;
        if (settled_next) begin
            acc_next = '0;
        end else if (integ_pre > lim_ext) begin
            acc_next = lim_ext;
        end else if (integ_pre < -lim_ext) begin
            acc_next = -lim_ext;
        end else begin
            acc_next = integ_pre;
        end
        deriv_next = DER_W'(err_reg) - DER_W'(prev_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end else if (adv_state) begin
            acc_reg  <= acc_next;
            prev_reg <= err_reg;
        end
    end

    logic signed [ERROR_WIDTH-1:0] s1_err_reg;
    logic signed [ACC_W-1:0]       s1_integ_reg;
    logic signed [DER_W-1:0]       s1_deriv_reg;
    logic                          s1_settled_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_err_reg     <= err_reg;
            s1_integ_reg   <= acc_next;
            s1_deriv_reg   <= deriv_next;
            s1_settled_reg <= settled_next;
        end
    end

    // ---------------- stage 2: three gain products ----------------
    logic signed [GAIN_W:0] gp_s, gi_s, gd_s;
    logic signed [PP_W-1:0] pp_next, pp_reg;
    logic signed [PI_W-1:0] pi_next, pi_reg;
    logic signed [PD_W-1:0] pd_next, pd_reg;
    logic                   s2_settled_reg;

    assign gp_s    = $signed({1'b0, gain_p_reg});
    assign gi_s    = $signed({1'b0, gain_i_reg});
    assign gd_s    = $signed({1'b0, gain_d_reg});
    assign pp_next = PP_W'(gp_s) * PP_W'(s1_err_reg);
    assign pi_next = PI_W'(gi_s) * PI_W'(s1_integ_reg);
    assign pd_next = PD_W'(gd_s) * PD_W'(s1_deriv_reg);

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            pp_reg         <= pp_next;
            pi_reg         <= pi_next;
            pd_reg         <= pd_next;
            s2_settled_reg <= s1_settled_reg;
        end
    end

    // ---------------- stage 3: sum ----------------
    logic signed [SUM_W-1:0] sum_next, sum_reg;
    logic                    s3_settled_reg;

    assign sum_next = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sum_reg        <= sum_next;
            s3_settled_reg <= s2_settled_reg;
        end
    end

    // ---------------- stage 4: shift, clamp, min drive ----------------
    logic signed [SHR_W-1:0]   shr, maxd_ext, mind_ext, clamped, shaped;
    logic signed [DRIVE_W-1:0] drive_next, drive_reg;
    logic                      settled_reg;

    always_comb begin
        // floor division by 256
        shr      = $signed(sum_reg[SUM_W-1:8]);
        maxd_ext = $signed(SHR_W'(max_drive_reg));
        mind_ext = $signed(SHR_W'(min_drive_reg));
        if (shr > maxd_ext) begin
            clamped = maxd_ext;
        end else if (shr < -maxd_ext) begin
            clamped = -maxd_ext;
        end else begin
            clamped = shr;
        end
        if (clamped > 0 && clamped < mind_ext) begin
            shaped = mind_ext;
        end else if (clamped < 0 && clamped > -mind_ext) begin
            shaped = -mind_ext;
        end else begin
            shaped = clamped;
        end
        drive_next = s3_settled_reg ? '0 : shaped[DRIVE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            drive_reg   <= drive_next;
            settled_reg <= s3_settled_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(drive_reg);
    assign m_tuser  = settled_reg;

    // ---------------- assertions ----------------
    `ASSERT_CLKD(a_settled_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (drive_reg == '0))
    `ASSERT_CLKD(a_state_hold, aclk, aresetn, !adv_state |=> $stable({acc_reg, prev_reg}))
    `ASSERT_CLKD(a_ready_when_empty, aclk, aresetn, !m_valid_reg |-> s_tready)
    `ASSERT_CLKD(a_out_fill, aclk, aresetn, (v3_reg && rdy4) |=> m_valid_reg)

endmodule

>>> tb/pid_step_min_drive_checker.sv
`timescale 1ns / 1ps
// Scoreboard for pid_step_min_drive_core: tracks APB writes, predicts each
// drive transaction from the accepted error samples and compares. Uses pidsmd_pkg.
module pid_step_min_drive_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // [ERROR_WIDTH-1:0] error_in
    input  logic [pidsmd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] drive
    input  logic [pidsmd_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] settled
    input  logic                              m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pidsmd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pidsmd_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic [pidsmd_pkg::CFG_DATA_W-1:0] prdata,
    input  logic                              pready,
    output int                                error_count,
    output int                                pending_count
);
    import pidsmd_pkg::*;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               settled;
    } drive_cmd_t;

    drive_cmd_t expected_drives[$];
    longint     cfg_val [8];
    longint     integ_acc;
    longint     last_error;

    initial begin
        error_count   = 0;
        pending_count = 0;
    end

    task automatic flag_error(string what, longint got, longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic longint reg_mask(cfg_reg_t r);
        case (r)
            REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: return (longint'(1) << GAIN_W) - 1;
            REG_MAX_DRIVE, REG_MIN_DRIVE:       return (longint'(1) << DCFG_W) - 1;
            default:                            return (longint'(1) << LIMIT_W) - 1;
        endcase
    endfunction

    function automatic longint limit_to(longint v, longint lim);
        if (v < -lim) return -lim;
        if (v > lim) return lim;
        return v;
    endfunction

    // one control tick; updates the integral and the last error
    function automatic drive_cmd_t pid_tick(logic [ERROR_WIDTH-1:0] raw);
        logic signed [ERROR_WIDTH-1:0] sraw;
        longint                        e, mag, total, cmd, floor_mag;
        drive_cmd_t                    res;
        sraw = raw;
        e = sraw;
        mag = (e < 0) ? -e : e;
        cmd = 0;
        res.settled = 1'b0;
        if (mag <= cfg_val[REG_SETTLE_THR]) begin
            integ_acc = 0;
            res.settled = 1'b1;
        end else begin
            integ_acc = (mag < cfg_val[REG_ACT_ZONE]) ? integ_acc + e : 0;
            integ_acc = limit_to(integ_acc, cfg_val[REG_INT_LIMIT]);
            total = cfg_val[REG_GAIN_P] * e + cfg_val[REG_GAIN_I] * integ_acc
                  + cfg_val[REG_GAIN_D] * (e - last_error);
            cmd = limit_to(total >>> 8, cfg_val[REG_MAX_DRIVE]);
            // min drive goes on after the clamp, so it may exceed max drive
            floor_mag = cfg_val[REG_MIN_DRIVE];
            if (cmd > 0 && cmd < floor_mag)
                cmd = floor_mag;
            else if (cmd < 0 && cmd > -floor_mag)
                cmd = -floor_mag;
        end
        last_error = e;
        res.drive = cmd[DRIVE_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        drive_cmd_t want;
        int         idx;
        if (!aresetn) begin
            expected_drives.delete();
            integ_acc  = 0;
            last_error = 0;
            cfg_val[REG_GAIN_P]     = RST_GAIN_P;
            cfg_val[REG_GAIN_I]     = RST_GAIN_I;
            cfg_val[REG_GAIN_D]     = RST_GAIN_D;
            cfg_val[REG_INT_LIMIT]  = RST_INT_LIMIT;
            cfg_val[REG_ACT_ZONE]   = RST_ACT_ZONE;
            cfg_val[REG_SETTLE_THR] = RST_SETTLE_THR;
            cfg_val[REG_MAX_DRIVE]  = RST_MAX_DRIVE;
            cfg_val[REG_MIN_DRIVE]  = RST_MIN_DRIVE;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_drives.size() == 0) begin
                    flag_error("drive transaction with nothing pending",
                               $signed(m_tdata[DRIVE_W-1:0]), 0);
                end else begin
                    want = expected_drives.pop_front();
                    if (m_tdata[DRIVE_W-1:0] !== want.drive)
                        flag_error("drive", $signed(m_tdata[DRIVE_W-1:0]),
                                   $signed(want.drive));
                    if (m_tuser !== want.settled)
                        flag_error("settled", m_tuser, want.settled);
                end
            end
            if (s_tvalid && s_tready)
                expected_drives.push_back(pid_tick(s_tdata[ERROR_WIDTH-1:0]));
            if (psel && penable && pready) begin
                idx = int'(paddr[CFG_ADDR_W-1:2]);
                if (pwrite)
                    cfg_val[idx] = longint'(pwdata) & reg_mask(cfg_reg_t'(idx));
                else if (prdata !== CFG_DATA_W'(cfg_val[idx]))
                    flag_error($sformatf("register %0d readback", idx), prdata, cfg_val[idx]);
            end
        end
        pending_count <= expected_drives.size();
    end

endmodule

>>> tb/pid_step_min_drive_core_tb.sv
`timescale 1ns / 1ps
// Top of the pid_step_min_drive_core testbench: clock, reset, APB setup and
// error-sample stimulus. Depends on pidsmd_pkg, the core and pid_step_min_drive_checker.
module pid_step_min_drive_core_tb;
    import pidsmd_pkg::*;

    localparam int     PIPE_LAT        = 5;
    localparam int     NUM_PHASES      = 8;
    localparam int     ITEMS_PER_PHASE = 92;
    localparam longint ERR_MAX         = 8388607;
    localparam longint ERR_MIN         = -8388608;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    error_count;
    int                    pending_count;

    int     idle_pct  = 0;
    int     stall_pct = 0;
    longint sh_thr    = RST_SETTLE_THR;
    longint sh_zone   = RST_ACT_ZONE;

    always #1 aclk = ~aclk;

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    pid_step_min_drive_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pid_step_min_drive_checker u_checker (.*);

    task automatic apb_xfer(bit wr, cfg_reg_t r, logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // junk above the register width now and then; the core must drop it
    task automatic set_reg(cfg_reg_t r, longint v, int w);
        logic [CFG_DATA_W-1:0] data;
        data = v[CFG_DATA_W-1:0];
        if ($urandom_range(3) == 0)
            data = data | ($urandom() << w);
        apb_xfer(1'b1, r, data);
    endtask

    task automatic load_config(longint gp, gi, gd, lim, zone, thr, maxd, mind);
        set_reg(REG_GAIN_P, gp, GAIN_W);
        set_reg(REG_GAIN_I, gi, GAIN_W);
        set_reg(REG_GAIN_D, gd, GAIN_W);
        set_reg(REG_INT_LIMIT, lim, LIMIT_W);
        set_reg(REG_ACT_ZONE, zone, LIMIT_W);
        set_reg(REG_SETTLE_THR, thr, LIMIT_W);
        set_reg(REG_MAX_DRIVE, maxd, DCFG_W);
        set_reg(REG_MIN_DRIVE, mind, DCFG_W);
        sh_thr  = thr;
        sh_zone = zone;
        for (int r = 0; r < 8; r++)
            apb_xfer(1'b0, cfg_reg_t'(r), '0);
    endtask

    task automatic send_error(longint e);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[ERROR_WIDTH-1:0] = e[ERROR_WIDTH-1:0];
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // pending_count is registered, so look past the edge of the last transaction
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (PIPE_LAT + 3) @(posedge aclk);
    endtask

    function automatic longint next_error();
        logic [ERROR_WIDTH-1:0]        raw;
        logic signed [ERROR_WIDTH-1:0] sraw;
        longint                        mag;
        int                            k;
        k = $urandom_range(99);
        if (k >= 75) begin
            raw  = ERROR_WIDTH'($urandom());
            sraw = raw;
            return sraw;
        end
        if (k < 15)
            mag = $urandom_range(0, sh_thr);
        else if (k < 45)
            mag = (sh_zone > sh_thr + 1) ? $urandom_range(sh_thr + 1, sh_zone - 1) : sh_thr + 1;
        else if (k < 60) begin
            case ($urandom_range(3))
                0: mag = sh_thr;
                1: mag = sh_thr + 1;
                2: mag = (sh_zone > 0) ? sh_zone - 1 : 0;
                default: mag = sh_zone;
            endcase
        end else begin
            case ($urandom_range(3))
                0: mag = ERR_MAX;
                1: mag = -ERR_MIN;
                2: mag = 1;
                default: mag = 0;
            endcase
        end
        if (mag > ERR_MAX) return ERR_MIN;
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // error that closes in on the target like a real loop, with some noise
    task automatic send_approach(output int n);
        longint e, span, nz;
        span = sh_zone * 3 + sh_thr + 16;
        if (span > ERR_MAX) span = ERR_MAX;
        nz = sh_thr / 2 + 1;
        if (nz > 4096) nz = 4096;
        e = $urandom_range(0, span);
        if ($urandom_range(1)) e = -e;
        n = $urandom_range(6, 20);
        repeat (n) begin
            send_error(e);
            e = e - e / 4 + longint'($urandom_range(0, 2 * nz)) - nz;
            if (e > ERR_MAX) e = ERR_MAX;
            if (e < ERR_MIN) e = ERR_MIN;
        end
    endtask

    initial begin
        #400000;
        $display("pid_step_min_drive_core_tb: errors");
        $finish;
    end

    initial begin
        int     sent;
        int     run_len;
        bit     held;
        longint maxd;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int r = 0; r < 8; r++)
            apb_xfer(1'b0, cfg_reg_t'(r), '0);

        // directed, reset config: settle edges, zone edges, clamps, min drive
        send_error(0);
        send_error(64);
        send_error(-64);
        send_error(65);
        send_error(-65);
        send_error(2559);
        send_error(-2559);
        send_error(2560);
        send_error(-2560);
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        send_error(100);
        send_error(100);
        send_error(-1);
        drain_pipe();
        // zero max drive: output stays zero, min drive does not apply
        load_config(768, 49, 0, 53895, 2560, 64, 0, 512);
        send_error(1000);
        send_error(-1000);
        drain_pipe();
        // min drive above max drive wins
        load_config(768, 0, 0, 53895, 2560, 64, 256, 25600);
        send_error(1000);
        send_error(-1000);
        drain_pipe();
        // floor rounding of the shift
        load_config(1, 0, 0, 0, 0, 0, 25600, 0);
        send_error(-1);
        send_error(255);
        send_error(-255);
        send_error(0);
        drain_pipe();
        // integral clamp and derivative
        load_config(0, 256, 256, 1000, ERR_MAX, 0, 25600, 0);
        send_error(600);
        send_error(600);
        send_error(600);
        send_error(-600);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipe();
            case (ph)
                0: load_config(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_INT_LIMIT,
                               RST_ACT_ZONE, RST_SETTLE_THR, RST_MAX_DRIVE, RST_MIN_DRIVE);
                2: load_config(65535, 65535, 65535, ERR_MAX, ERR_MAX, 0, 25600, 25600);
                3: load_config(0, 0, 0, 0, 0, 0, 0, 0);
                4: begin
                    maxd = $urandom_range(0, 2000);
                    load_config($urandom_range(0, 2048), $urandom_range(0, 256),
                                $urandom_range(0, 1024), $urandom_range(0, 200000),
                                $urandom_range(256, 8192), $urandom_range(0, 256),
                                maxd, $urandom_range(maxd + 1, 25600));
                end
                5: load_config($urandom() & 16'hFFFF, $urandom() & 16'hFFFF,
                               $urandom() & 16'hFFFF, $urandom() & 23'h7FFFFF,
                               $urandom() & 23'h7FFFFF, $urandom() & 23'h7FFFFF,
                               $urandom_range(0, 25600), $urandom_range(0, 25600));
                7: load_config($urandom_range(0, 2048), $urandom_range(0, 256),
                               $urandom_range(0, 1024), $urandom_range(0, 200000),
                               ERR_MAX, ERR_MAX, 25600, $urandom_range(0, 2048));
                default: load_config($urandom_range(0, 2048), $urandom_range(0, 256),
                                     $urandom_range(0, 1024), $urandom_range(0, 200000),
                                     $urandom_range(256, 8192), $urandom_range(0, 256),
                                     $urandom_range(0, 25600), $urandom_range(0, 2048));
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            sent = 0;
            held = 1'b0;
            while (sent < ITEMS_PER_PHASE) begin
                // hold the sender off until the pipe is empty once per phase
                if (!held && sent >= ITEMS_PER_PHASE / 2) begin
                    drain_pipe();
                    held = 1'b1;
                end
                if ($urandom_range(99) < 60) begin
                    send_approach(run_len);
                    sent += run_len;
                end else begin
                    send_error(next_error());
                    sent++;
                end
            end
        end

        drain_pipe();
        if (error_count == 0)
            $display("pid_step_min_drive_core_tb: clean");
        else
            $display("pid_step_min_drive_core_tb: errors");
        $finish;
    end

endmodule
